// ===== hw/rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg: shared constants for the SSS triangle solver
// Normalized angle frame, CORDIC step count and arctangent table in degrees.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

  // normalized frame: the double product 2xy lands in [2^29, 2^30)
  localparam int NORM_BITS = 30;
  localparam int SQ_W      = 2 * NORM_BITS;
  localparam int ROOT_W    = NORM_BITS;
  localparam int X0_W      = NORM_BITS + 1;
  localparam int XY_W      = NORM_BITS + 4;

  // CORDIC angle accumulator, degrees Q.16
  localparam int CORDIC_STEPS = 22;
  localparam int ZFRAC        = 16;
  localparam int Z_W          = 26;

  localparam logic signed [Z_W-1:0] ATAN_DEG_Q16 [CORDIC_STEPS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
    26'sd117304,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
    26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
    26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7,
    26'sd4,       26'sd2
  };

  localparam logic signed [Z_W-1:0] Z_RIGHT    = 26'sd5898240;   // 90 degrees
  localparam logic signed [Z_W-1:0] Z_STRAIGHT = 26'sd11796480;  // 180 degrees

  // triangle class codes
  localparam logic [1:0] CLASS_RIGHT  = 2'd0;
  localparam logic [1:0] CLASS_ACUTE  = 2'd1;
  localparam logic [1:0] CLASS_OBTUSE = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/tss_in_if.sv =====
// ----------------------------------------------------------------------------
// tss_in_if: side-length word channel
// Valid/ready channel carrying three unsigned Q12.4 side lengths.
// ----------------------------------------------------------------------------
`default_nettype none

interface tss_in_if #(
  parameter int SIDE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [SIDE_BITS-1:0] side_a;
  logic [SIDE_BITS-1:0] side_b;
  logic [SIDE_BITS-1:0] side_c;

  modport source (output valid, side_a, side_b, side_c, input ready);
  modport sink   (input valid, side_a, side_b, side_c, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tss_out_if.sv =====
// ----------------------------------------------------------------------------
// tss_out_if: triangle result word channel
// Valid/ready channel carrying existence, perimeter, area, angles and class.
// ----------------------------------------------------------------------------
`default_nettype none

interface tss_out_if #(
  parameter int SIDE_BITS       = 16,
  parameter int ANGLE_FRAC_BITS = 8
);
  logic                         valid;
  logic                         ready;
  logic                         triangle_exists;
  logic [SIDE_BITS+1:0]         perimeter;
  logic [2*SIDE_BITS-6:0]       area;
  logic [ANGLE_FRAC_BITS+7:0]   angle_alpha;
  logic [ANGLE_FRAC_BITS+7:0]   angle_beta;
  logic [ANGLE_FRAC_BITS+7:0]   angle_gamma;
  logic [1:0]                   triangle_class;

  modport source (output valid, triangle_exists, perimeter, area, angle_alpha,
                  angle_beta, angle_gamma, triangle_class, input ready);
  modport sink   (input valid, triangle_exists, perimeter, area, angle_alpha,
                  angle_beta, angle_gamma, triangle_class, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tss_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tss_sqrt_cell: one root bit of a pipelined integer square root
// Restoring digit step at a fixed bit position, plus a carried payload.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_sqrt_cell #(
  parameter int VW = 60,
  parameter int K  = 29,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [VW-1:0] v_in,
  input  wire logic [VW-1:0] r_in,
  input  wire logic [PW-1:0] pay_in,
  output logic      [VW-1:0] v_out,
  output logic      [VW-1:0] r_out,
  output logic      [PW-1:0] pay_out
);

  localparam logic [VW:0] BIT = {{VW{1'b0}}, 1'b1} << (2 * K);

  logic [VW:0]   trial;
  logic          fits;
  logic [VW-1:0] v_next;
  logic [VW-1:0] r_next;

  // try root bit: subtract when remainder covers it
  always_comb begin
    trial = {1'b0, r_in} + BIT;
    fits  = ({1'b0, v_in} >= trial);
    if (fits) begin
      v_next = v_in - trial[VW-1:0];
      r_next = (r_in >> 1) + BIT[VW-1:0];
    end else begin
      v_next = v_in;
      r_next = r_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out   <= v_next;
      r_out   <= r_next;
      pay_out <= pay_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tss_norm_cell.sv =====
// ----------------------------------------------------------------------------
// tss_norm_cell: one step of the leading-zero normalizer
// Shifts the denominator, cosine term and sine-squared term by a fixed amount
// when the top bits of the denominator are all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_norm_cell #(
  parameter int W  = 33,
  parameter int SH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [W-1:0]         d_in,
  input  wire logic signed [W:0]    n_in,
  input  wire logic [2*W-1:0]       q_in,
  output logic      [W-1:0]         d_out,
  output logic signed [W:0]         n_out,
  output logic      [2*W-1:0]       q_out
);

  logic hit;

  assign hit = (d_in[W-1 -: SH] == '0);

  // q scales by the square of the shift
  always_ff @(posedge clk) begin
    if (en) begin
      if (hit) begin
        d_out <= d_in << SH;
        n_out <= n_in <<< SH;
        q_out <= q_in << (2 * SH);
      end else begin
        d_out <= d_in;
        n_out <= n_in;
        q_out <= q_in;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tss_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tss_cordic_cell: one CORDIC vectoring rotation
// Drives y toward zero and accumulates the rotated angle in degrees Q.16.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic signed [tss_pkg::XY_W-1:0] x_in,
  input  wire logic signed [tss_pkg::XY_W-1:0] y_in,
  input  wire logic signed [tss_pkg::Z_W-1:0]  z_in,
  output logic      signed [tss_pkg::XY_W-1:0] x_out,
  output logic      signed [tss_pkg::XY_W-1:0] y_out,
  output logic      signed [tss_pkg::Z_W-1:0]  z_out
);

  import tss_pkg::*;

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  // rotate by -atan when y is positive, else by +atan
  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in > 0) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN_DEG_Q16[STEP];
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN_DEG_Q16[STEP];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tss_angle_lane.sv =====
// ----------------------------------------------------------------------------
// tss_angle_lane: one law-of-cosines angle
// Normalizer chain, square-root chain for the sine term, quadrant fold,
// CORDIC chain and final clamp and rounding to degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_angle_lane #(
  parameter int SIDE_BITS       = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [2*SIDE_BITS+1:0] n,
  input  wire logic [2*SIDE_BITS:0]        d,
  input  wire logic [4*SIDE_BITS+1:0]      q,
  output logic      [ANGLE_FRAC_BITS+7:0]  angle
);

  import tss_pkg::*;

  localparam int W   = 2 * SIDE_BITS + 1;
  localparam int NS  = $clog2(W);
  localparam int AW  = ANGLE_FRAC_BITS + 8;
  localparam int ZSH = ZFRAC - ANGLE_FRAC_BITS;

  // normalizer chain
  logic [W-1:0]        d_s [NS+1];
  logic signed [W:0]   n_s [NS+1];
  logic [2*W-1:0]      q_s [NS+1];

  assign d_s[0] = d;
  assign n_s[0] = n;
  assign q_s[0] = q;

  for (genvar j = 0; j < NS; j++) begin : g_norm
    tss_norm_cell #(.W(W), .SH(1 << (NS - 1 - j))) u_norm (
      .clk   (clk),
      .en    (en),
      .d_in  (d_s[j]),
      .n_in  (n_s[j]),
      .q_in  (q_s[j]),
      .d_out (d_s[j+1]),
      .n_out (n_s[j+1]),
      .q_out (q_s[j+1])
    );
  end

  // fixed rescale into the 30-bit frame; right shifts floor
  logic signed [X0_W-1:0] x0;
  logic [SQ_W-1:0]        ysq;

  if (W >= NORM_BITS) begin : g_down
    localparam int E = W - NORM_BITS;
    logic signed [W:0] n_sh;
    logic [2*W-1:0]    q_sh;
    assign n_sh = n_s[NS] >>> E;
    assign q_sh = q_s[NS] >> (2 * E);
    assign x0   = n_sh[X0_W-1:0];
    assign ysq  = q_sh[SQ_W-1:0];
  end else begin : g_up
    localparam int KU = NORM_BITS - W;
    assign x0  = X0_W'(n_s[NS]) <<< KU;
    assign ysq = SQ_W'(q_s[NS]) << (2 * KU);
  end

  // square-root chain for the sine term, cosine term rides along
  logic [SQ_W-1:0] v_c [ROOT_W+1];
  logic [SQ_W-1:0] r_c [ROOT_W+1];
  logic [X0_W-1:0] x_c [ROOT_W+1];

  assign v_c[0] = ysq;
  assign r_c[0] = '0;
  assign x_c[0] = x0;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    tss_sqrt_cell #(.VW(SQ_W), .K(ROOT_W - 1 - j), .PW(X0_W)) u_sqrt (
      .clk     (clk),
      .en      (en),
      .v_in    (v_c[j]),
      .r_in    (r_c[j]),
      .pay_in  (x_c[j]),
      .v_out   (v_c[j+1]),
      .r_out   (r_c[j+1]),
      .pay_out (x_c[j+1])
    );
  end

  // quadrant fold: negative cosine rotates by -90 and starts at 90 degrees
  logic signed [X0_W-1:0] xs;
  logic [ROOT_W-1:0]      ys;
  logic signed [XY_W-1:0] x_p;
  logic signed [XY_W-1:0] y_p;
  logic signed [Z_W-1:0]  z_p;

  assign xs = $signed(x_c[ROOT_W]);
  assign ys = r_c[ROOT_W][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (xs < 0) begin
        x_p <= XY_W'($signed({1'b0, ys}));
        y_p <= -XY_W'(xs);
        z_p <= Z_RIGHT;
      end else begin
        x_p <= XY_W'(xs);
        y_p <= XY_W'($signed({1'b0, ys}));
        z_p <= '0;
      end
    end
  end

  // CORDIC chain
  logic signed [XY_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y_r [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_r [CORDIC_STEPS+1];

  assign x_r[0] = x_p;
  assign y_r[0] = y_p;
  assign z_r[0] = z_p;

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    tss_cordic_cell #(.STEP(j)) u_cordic (
      .clk   (clk),
      .en    (en),
      .x_in  (x_r[j]),
      .y_in  (y_r[j]),
      .z_in  (z_r[j]),
      .x_out (x_r[j+1]),
      .y_out (y_r[j+1]),
      .z_out (z_r[j+1])
    );
  end

  // clamp to [0, 180] degrees, then round half up
  logic signed [Z_W-1:0] zf;
  logic [Z_W-1:0]        zc;
  logic [AW-1:0]         angle_next;

  assign zf = z_r[CORDIC_STEPS];

  always_comb begin
    if (zf < 0) begin
      zc = '0;
    end else if (zf > Z_STRAIGHT) begin
      zc = $unsigned(Z_STRAIGHT);
    end else begin
      zc = $unsigned(zf);
    end
  end

  if (ZSH > 0) begin : g_round
    logic [Z_W-1:0] zr;
    assign zr         = (zc + (Z_W'(1) << (ZSH - 1))) >> ZSH;
    assign angle_next = zr[AW-1:0];
  end else begin : g_exact
    assign angle_next = zc[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_solver_sss_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_solver_sss_unit: triangle solver from three side lengths
// Existence check, perimeter, Heron area, three angles and classification.
// ----------------------------------------------------------------------------
// Usage:
//   sides  : input word channel, three unsigned Q12.4 side lengths.
//   result : output word channel, one result word per input word.
//   A word is taken when valid and ready are both high.
//   Throughput: one word per cycle unless stalled. Every stage is a register
//   cell in a chain (normalizer, square-root and CORDIC cells per angle, a
//   square-root chain for the area), so a new word can enter on every cycle.
//   Stall: while result.valid is high and result.ready is low the whole
//   chain holds and sides.ready is low; the waiting result stays stable.
//   Reset: rst clears all valid bits; payload registers are not reset.
//   Triangles that fail the strict inequality give all-zero fields with
//   class right.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_solver_sss_unit #(
  parameter int SIDE_BITS       = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input wire logic  clk,
  input wire logic  rst,
  tss_in_if.sink    sides,
  tss_out_if.source result
);

  import tss_pkg::*;

  localparam int S      = SIDE_BITS;
  localparam int PERW   = S + 2;
  localparam int AREA_W = 2 * S - 5;
  localparam int AW     = ANGLE_FRAC_BITS + 8;
  localparam int W      = 2 * S + 1;
  localparam int NS     = $clog2(W);
  localparam int F1W    = 2 * S + 3;
  localparam int F2W    = 2 * S + 2;
  localparam int H      = F2W / 2;
  localparam int PPW    = F1W + H;
  localparam int QW     = 4 * S + 2;
  localparam int NW     = 2 * S + 2;
  localparam int VW     = QW - 12;
  localparam int AC     = VW / 2;
  localparam int LAT    = NS + ROOT_W + CORDIC_STEPS + 2;
  localparam int PAD    = LAT - AC;
  localparam int NV     = 4 + LAT;
  localparam int APW    = 1 + PERW;
  localparam int PADW   = APW + AREA_W;

  localparam logic [AW-1:0] ANG_RIGHT    = AW'(90) << ANGLE_FRAC_BITS;
  localparam logic [AW-1:0] ANG_LO       = ANG_RIGHT - (AW'(1) << (ANGLE_FRAC_BITS - 1));
  localparam logic [AW-1:0] ANG_HI       = ANG_RIGHT + (AW'(1) << (ANGLE_FRAC_BITS - 1));
  localparam logic [AW-1:0] ANG_STRAIGHT = AW'(180) << ANGLE_FRAC_BITS;

  // global advance: the chain moves unless a finished word is held
  logic adv;
  assign adv         = !result.valid || result.ready;
  assign sides.ready = adv;

  logic [NV-1:0] vld;

  // stage 1: sums, existence, perimeter
  logic [S:0]      sab, sbc, sac;
  logic            ex_next;
  logic [S-1:0]    a1, b1, c1;
  logic [PERW-1:0] p1;
  logic [S:0]      pa1, pb1, pc1;
  logic            ex1;

  always_comb begin
    sab     = {1'b0, sides.side_a} + {1'b0, sides.side_b};
    sbc     = {1'b0, sides.side_b} + {1'b0, sides.side_c};
    sac     = {1'b0, sides.side_a} + {1'b0, sides.side_c};
    ex_next = (sab > {1'b0, sides.side_c}) && (sbc > {1'b0, sides.side_a}) &&
              (sac > {1'b0, sides.side_b});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1  <= sides.side_a;
      b1  <= sides.side_b;
      c1  <= sides.side_c;
      p1  <= PERW'(sab) + PERW'(sides.side_c);
      pa1 <= sbc - {1'b0, sides.side_a};
      pb1 <= sac - {1'b0, sides.side_b};
      pc1 <= sab - {1'b0, sides.side_c};
      ex1 <= ex_next;
    end
  end

  // stage 2: Heron factors, squares and cross products
  logic [F1W-1:0]  f1_2;
  logic [F2W-1:0]  f2_2;
  logic [2*S-1:0]  a2_2, b2_2, c2_2, bc_2, ac_2, ab_2;
  logic [PERW-1:0] p2;
  logic            ex2;

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_2 <= F1W'(p1) * F1W'(pa1);
      f2_2 <= F2W'(pb1) * F2W'(pc1);
      a2_2 <= (2*S)'(a1) * (2*S)'(a1);
      b2_2 <= (2*S)'(b1) * (2*S)'(b1);
      c2_2 <= (2*S)'(c1) * (2*S)'(c1);
      bc_2 <= (2*S)'(b1) * (2*S)'(c1);
      ac_2 <= (2*S)'(a1) * (2*S)'(c1);
      ab_2 <= (2*S)'(a1) * (2*S)'(b1);
      p2   <= p1;
      ex2  <= ex1;
    end
  end

  // stage 3: split Heron product, cosine numerators and denominators
  logic [PPW-1:0]       pl3, ph3;
  logic signed [NW-1:0] na3, nb3, nc3;
  logic [W-1:0]         da3, db3, dc3;
  logic [PERW-1:0]      p3;
  logic                 ex3;

  always_ff @(posedge clk) begin
    if (adv) begin
      pl3 <= PPW'(f1_2) * PPW'(f2_2[H-1:0]);
      ph3 <= PPW'(f1_2) * PPW'(f2_2[F2W-1:H]);
      na3 <= NW'(b2_2) + NW'(c2_2) - NW'(a2_2);
      nb3 <= NW'(a2_2) + NW'(c2_2) - NW'(b2_2);
      nc3 <= NW'(a2_2) + NW'(b2_2) - NW'(c2_2);
      da3 <= {bc_2, 1'b0};
      db3 <= {ac_2, 1'b0};
      dc3 <= {ab_2, 1'b0};
      p3  <= p2;
      ex3 <= ex2;
    end
  end

  // stage 4: full Heron product 16*area^2
  logic [QW-1:0]        q4;
  logic signed [NW-1:0] na4, nb4, nc4;
  logic [W-1:0]         da4, db4, dc4;
  logic [PERW-1:0]      p4;
  logic                 ex4;

  always_ff @(posedge clk) begin
    if (adv) begin
      q4  <= QW'(pl3) + (QW'(ph3) << H);
      na4 <= na3;
      nb4 <= nb3;
      nc4 <= nc3;
      da4 <= da3;
      db4 <= db3;
      dc4 <= dc3;
      p4  <= p3;
      ex4 <= ex3;
    end
  end

  // angle lanes
  logic [AW-1:0] ang_a, ang_b, ang_c;

  tss_angle_lane #(.SIDE_BITS(S), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_alpha (
    .clk (clk), .en (adv), .n (na4), .d (da4), .q (q4), .angle (ang_a)
  );

  tss_angle_lane #(.SIDE_BITS(S), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_beta (
    .clk (clk), .en (adv), .n (nb4), .d (db4), .q (q4), .angle (ang_b)
  );

  tss_angle_lane #(.SIDE_BITS(S), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_lane_gamma (
    .clk (clk), .en (adv), .n (nc4), .d (dc4), .q (q4), .angle (ang_c)
  );

  // area square-root chain; existence and perimeter ride along
  logic [VW-1:0]  v_a   [AC+1];
  logic [VW-1:0]  r_a   [AC+1];
  logic [APW-1:0] pay_a [AC+1];

  assign v_a[0]   = q4[QW-1:12];
  assign r_a[0]   = '0;
  assign pay_a[0] = {ex4, p4};

  for (genvar j = 0; j < AC; j++) begin : g_area
    tss_sqrt_cell #(.VW(VW), .K(AC - 1 - j), .PW(APW)) u_area (
      .clk     (clk),
      .en      (adv),
      .v_in    (v_a[j]),
      .r_in    (r_a[j]),
      .pay_in  (pay_a[j]),
      .v_out   (v_a[j+1]),
      .r_out   (r_a[j+1]),
      .pay_out (pay_a[j+1])
    );
  end

  // delay line to meet the angle lanes
  logic [PADW-1:0] pad_q [PAD];

  always_ff @(posedge clk) begin
    if (adv) begin
      pad_q[0] <= {pay_a[AC], r_a[AC][AREA_W-1:0]};
      for (int i = 1; i < PAD; i++) begin
        pad_q[i] <= pad_q[i-1];
      end
    end
  end

  logic              ex_f;
  logic [PERW-1:0]   p_f;
  logic [AREA_W-1:0] area_f;

  assign {ex_f, p_f, area_f} = pad_q[PAD-1];

  // classification
  logic       is_right;
  logic       not_acute;
  logic [1:0] class_next;

  always_comb begin
    is_right  = ((ang_a >= ANG_LO) && (ang_a < ANG_HI)) ||
                ((ang_b >= ANG_LO) && (ang_b < ANG_HI)) ||
                ((ang_c >= ANG_LO) && (ang_c < ANG_HI));
    not_acute = (ang_a >= ANG_RIGHT) || (ang_b >= ANG_RIGHT) || (ang_c >= ANG_RIGHT);
    if (is_right) begin
      class_next = CLASS_RIGHT;
    end else if (!not_acute) begin
      class_next = CLASS_ACUTE;
    end else begin
      class_next = CLASS_OBTUSE;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (adv) begin
      result.triangle_exists <= ex_f;
      if (ex_f) begin
        result.perimeter      <= p_f;
        result.area           <= area_f;
        result.angle_alpha    <= ang_a;
        result.angle_beta     <= ang_b;
        result.angle_gamma    <= ang_c;
        result.triangle_class <= class_next;
      end else begin
        result.perimeter      <= '0;
        result.area           <= '0;
        result.angle_alpha    <= '0;
        result.angle_beta     <= '0;
        result.angle_gamma    <= '0;
        result.triangle_class <= CLASS_RIGHT;
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result.valid <= 1'b0;
    end else if (adv) begin
      vld          <= {vld[NV-2:0], sides.valid};
      result.valid <= vld[NV-1];
    end
  end

  // checks
  a_no_triangle_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.triangle_exists |->
      result.perimeter == '0 && result.area == '0 && result.angle_alpha == '0 &&
      result.triangle_class == CLASS_RIGHT)
    else $error("no-triangle word carries nonzero fields");

  a_ready_only_on_hold: assert property (@(posedge clk) disable iff (rst)
    !sides.ready |-> result.valid && !result.ready)
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.angle_alpha <= ANG_STRAIGHT &&
      result.angle_beta <= ANG_STRAIGHT && result.angle_gamma <= ANG_STRAIGHT)
    else $error("angle beyond 180 degrees");

endmodule

`default_nettype wire
